@@ hdl/upd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package upd_pkg;

   localparam int ByteWidth = 8;
   localparam int NibbleWidth = 4;
   localparam int PhaseWidth = 2;

   // escape phase codes
   localparam logic [PhaseWidth-1:0] PHASE_PLAIN = 2'd0;
   localparam logic [PhaseWidth-1:0] PHASE_HIGH = 2'd1;
   localparam logic [PhaseWidth-1:0] PHASE_LOW = 2'd2;

   localparam logic [ByteWidth-1:0] CHAR_PERCENT = 8'h25;
   localparam logic [ByteWidth-1:0] CHAR_PLUS = 8'h2B;
   localparam logic [ByteWidth-1:0] CHAR_SPACE = 8'h20;
   localparam logic [ByteWidth-1:0] CHAR_ZERO = 8'h30;
   localparam logic [ByteWidth-1:0] CHAR_NINE = 8'h39;
   localparam logic [ByteWidth-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [ByteWidth-1:0] CHAR_UPPER_F = 8'h46;
   localparam logic [ByteWidth-1:0] CHAR_NUL = 8'h00;

   typedef struct packed {
      logic [PhaseWidth-1:0]  phase;
      logic [NibbleWidth-1:0] high_nibble;
   } upd_state_type;

   typedef struct packed {
      logic [ByteWidth-1:0] out_byte;
      logic                 out_valid;
      logic                 out_last;
   } upd_result_type;

   // hex digit value, 5 bits wide: a nul digit counts as 16
   function automatic logic [NibbleWidth:0] digit_value(input logic [ByteWidth-1:0] b);
      logic [NibbleWidth:0] v;
      v = '0;
      if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
         v = 5'((b - CHAR_ZERO) & 8'h0F);
      end else if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_F) begin
         v = 5'(((b - CHAR_UPPER_A) & 8'h0F) + 8'd10);
      end else if (b == CHAR_NUL) begin
         v = 5'd16;
      end
      return v;
   endfunction

endpackage

`default_nettype wire

@@ hdl/upd_decode.sv @@
`timescale 1ns / 1ps
`default_nettype none

module upd_decode import upd_pkg::*; (
   input  wire upd_state_type        state_cur,
   input  wire logic [ByteWidth-1:0] in_byte,
   input  wire logic                 end_of_string,
   output upd_state_type             state_nxt,
   output upd_result_type            result
);

   logic [NibbleWidth:0] dig;

   always_comb begin
      dig = digit_value(in_byte);
      state_nxt.phase = PHASE_PLAIN;
      state_nxt.high_nibble = state_cur.high_nibble;
      result.out_byte = '0;
      result.out_valid = 1'b0;
      result.out_last = end_of_string;
      priority if (state_cur.phase == PHASE_HIGH) begin
         state_nxt.high_nibble = dig[NibbleWidth-1:0];
         state_nxt.phase = PHASE_LOW;
      end else if (state_cur.phase == PHASE_LOW) begin
         // nul low digit sets bit 4 on top of the high nibble
         result.out_byte = {state_cur.high_nibble, {NibbleWidth{1'b0}}}
                           | {{(ByteWidth-NibbleWidth-1){1'b0}}, dig};
         result.out_valid = 1'b1;
      end else begin
         // plain, and the unreachable fourth code
         priority if (in_byte == CHAR_PERCENT) begin
            state_nxt.phase = PHASE_HIGH;
         end else if (in_byte == CHAR_PLUS) begin
            result.out_byte = CHAR_SPACE;
            result.out_valid = 1'b1;
         end else begin
            result.out_byte = in_byte;
            result.out_valid = 1'b1;
         end
      end
      // string end drops any open escape
      if (end_of_string) begin
         state_nxt.phase = PHASE_PLAIN;
      end
   end

endmodule

`default_nettype wire

@@ hdl/url_percent_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// url percent decoder: takes one byte of an escaped string per request and returns
// exactly one result per request, one per clock when neither side stalls. a '+'
// comes out as a space, '%' opens an escape whose next two bytes are hex digits
// (only 0-9 and A-F; a nul digit counts 16, anything else 0) that form one byte,
// and every other byte passes through. req_tlast marks the last byte of a string;
// an escape cut short by it is dropped, and rsp_tuser low says that no byte was
// produced (rsp_tdata is then zero). each request passes an input register and then a
// result register on its way to the output; the escape phase and pending high
// nibble advance as a request moves from the input register into the result
// register.

module url_percent_decoder import upd_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [ByteWidth-1:0] req_tdata,   // [7:0] in_byte
   input  wire logic                 req_tlast,   // end_of_string
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [ByteWidth-1:0]      rsp_tdata,   // [7:0] out_byte
   output logic                      rsp_tuser,   // out_valid
   output logic                      rsp_tlast    // out_last
);

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic [ByteWidth-1:0] in_byte_ff;
   logic                 in_last_ff;

   // result register
   logic                 out_valid_ff, out_valid_in;
   upd_result_type       out_ff;

   // decoder state
   upd_state_type        state_ff, state_in;
   upd_result_type       result;

   logic                 advance;
   logic                 req_take;

   // the input register moves on when the result register is empty or being read
   assign advance = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign req_take = req_tvalid && req_tready;

   upd_decode u_decode (
      .state_cur     (state_ff),
      .in_byte       (in_byte_ff),
      .end_of_string (in_last_ff),
      .state_nxt     (state_in),
      .result        (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff.phase <= PHASE_PLAIN;
         state_ff.high_nibble <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         // state advances only when a request is decoded into the result register
         if (advance && in_valid_ff) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && in_valid_ff) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_ff.out_byte;
   assign rsp_tuser = out_ff.out_valid;
   assign rsp_tlast = out_ff.out_last;

endmodule

`default_nettype wire

@@ hdl/upd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module upd_checker import upd_pkg::*; (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_tvalid,
   input wire logic                 req_tready,
   input wire logic                 rsp_tvalid,
   input wire logic                 rsp_tready,
   input wire logic [ByteWidth-1:0] rsp_tdata,
   input wire logic                 rsp_tuser,
   input wire logic                 rsp_tlast
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // no byte produced means a zero data field
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("dropped result carries data");

   // after reset nothing is held and a request can be taken
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

   // two entries of buffering: a request taken under a stall fills the pipe
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready && req_tvalid && req_tready) ##1 !rsp_tready
         |-> !req_tready)
      else $error("request taken with the pipe full");

endmodule

bind url_percent_decoder upd_checker u_upd_checker (.*);

`default_nettype wire

@@ tb/sv/upd_decode_checker.sv @@
`timescale 1ns / 1ps

module upd_decode_checker import upd_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   input  wire logic                 req_tready,
   input  wire logic [ByteWidth-1:0] req_tdata,   // [7:0] in_byte
   input  wire logic                 req_tlast,   // end_of_string
   input  wire logic                 rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire logic [ByteWidth-1:0] rsp_tdata,   // [7:0] out_byte
   input  wire logic                 rsp_tuser,   // out_valid
   input  wire logic                 rsp_tlast,   // out_last
   output int                        mismatch_count,
   output int                        pending_results,
   output int                        escapes_decoded,
   output int                        escapes_dropped,
   output int                        strings_seen
);

   logic [PhaseWidth-1:0]  esc_phase = PHASE_PLAIN;
   logic [NibbleWidth-1:0] pending_hi = '0;
   upd_result_type         decoded_q[$];
   int                     errors;
   int                     n_decoded;
   int                     n_dropped;
   int                     n_strings;

   // digit weight: nul counts 16, anything outside 0-9/A-F counts 0
   function automatic logic [NibbleWidth:0] hex_weight(input logic [ByteWidth-1:0] ch);
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         return 5'(ch - CHAR_ZERO);
      end else if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_F) begin
         return 5'(ch - CHAR_UPPER_A + 8'd10);
      end else if (ch == CHAR_NUL) begin
         return 5'd16;
      end
      return 5'd0;
   endfunction

   // advances the escape state by one request and returns its result
   function automatic upd_result_type decode_request(input logic [ByteWidth-1:0] ch,
                                                      input logic last);
      upd_result_type        res;
      logic [NibbleWidth:0]  w;
      logic [PhaseWidth-1:0] next_phase;
      res = '0;
      next_phase = PHASE_PLAIN;
      w = hex_weight(ch);
      case (esc_phase)
         PHASE_HIGH: begin
            pending_hi = w[NibbleWidth-1:0];
            next_phase = PHASE_LOW;
            if (last) n_dropped++;
         end
         PHASE_LOW: begin
            res.out_byte = {pending_hi, 4'h0} | {3'b000, w};
            res.out_valid = 1'b1;
            n_decoded++;
         end
         default: begin
            if (ch == CHAR_PERCENT) begin
               next_phase = PHASE_HIGH;
               if (last) n_dropped++;
            end else if (ch == CHAR_PLUS) begin
               res.out_byte = CHAR_SPACE;
               res.out_valid = 1'b1;
            end else begin
               res.out_byte = ch;
               res.out_valid = 1'b1;
            end
         end
      endcase
      res.out_last = last;
      if (last) begin
         next_phase = PHASE_PLAIN;
         n_strings++;
      end
      esc_phase = next_phase;
      return res;
   endfunction

   function automatic void check_field(input string field, input logic [ByteWidth-1:0] want_v,
                                       input logic [ByteWidth-1:0] got_v);
      if (got_v !== want_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, field, want_v, got_v);
      end
   endfunction

   always @(posedge clock) begin
      upd_result_type got;
      upd_result_type want;
      if (reset) begin
         esc_phase = PHASE_PLAIN;
         pending_hi = '0;
         decoded_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.out_byte = rsp_tdata;
            got.out_valid = rsp_tuser;
            got.out_last = rsp_tlast;
            if (decoded_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none actual %h/%b/%b", $time,
                        got.out_byte, got.out_valid, got.out_last);
            end else begin
               want = decoded_q.pop_front();
               check_field("out_byte", want.out_byte, got.out_byte);
               check_field("out_valid", 8'(want.out_valid), 8'(got.out_valid));
               check_field("out_last", 8'(want.out_last), 8'(got.out_last));
            end
         end
         if (req_tvalid && req_tready) begin
            decoded_q.push_back(decode_request(req_tdata, req_tlast));
         end
      end
      mismatch_count <= errors;
      pending_results <= decoded_q.size();
      escapes_decoded <= n_decoded;
      escapes_dropped <= n_dropped;
      strings_seen <= n_strings;
   end

endmodule

@@ tb/sv/tb_url_percent_decoder.sv @@
`timescale 1ns / 1ps

module tb_url_percent_decoder;
   import upd_pkg::*;

   localparam int RandomItems = 900;
   localparam int QuietTail = 120;       // requests at the end sent with no idling
   localparam int CycleLimit = 400000;
   localparam int SettleCycles = 8;      // two register stages plus margin

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [ByteWidth-1:0] req_tdata = '0;   // [7:0] in_byte
   logic                 req_tlast = 1'b0; // end_of_string
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [ByteWidth-1:0] rsp_tdata;        // [7:0] out_byte
   logic                 rsp_tuser;        // out_valid
   logic                 rsp_tlast;        // out_last

   int mismatch_count;
   int pending_results;
   int escapes_decoded;
   int escapes_dropped;
   int strings_seen;

   int items_sent;
   int cycle_count;
   int sender_idle_odds = 4;   // 0 turns sender gaps off for the current string
   bit quiet_tail;             // set for the last stretch: no idling on either side
   int stall_left;
   int calm_left;
   logic [ByteWidth-1:0] text_q[$];

   url_percent_decoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   upd_decode_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results),
      .escapes_decoded (escapes_decoded),
      .escapes_dropped (escapes_dropped),
      .strings_seen    (strings_seen)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // hard stop in case the block hangs or drops a result
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("url_percent_decoder test failed");
         $finish;
      end
   end

   // result side: random stall bursts, calm windows, always ready in the tail
   always @(negedge clock) begin
      if (quiet_tail || reset) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (calm_left > 0) begin
         rsp_tready <= 1'b1;
         calm_left--;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 17) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(20, 80);
      end
   end

   // one request; may open with an idle gap, returns once the block took it
   task automatic send_byte(input logic [ByteWidth-1:0] ch, input logic last);
      int gap;
      if (!quiet_tail && sender_idle_odds != 0 && $urandom_range(1, sender_idle_odds) == 1) begin
         gap = $urandom_range(1, 17);
         @(negedge clock) req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= ch;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // mostly real hex digits, sometimes nul, lowercase or arbitrary bytes
   function automatic logic [ByteWidth-1:0] pick_digit();
      int d;
      case ($urandom_range(0, 9))
         0: return CHAR_NUL;
         1: return 8'($urandom_range(8'h61, 8'h66));
         2: return 8'($urandom);
         default: begin
            d = $urandom_range(0, 15);
            return (d < 10) ? CHAR_ZERO + 8'(d) : CHAR_UPPER_A + 8'(d - 10);
         end
      endcase
   endfunction

   // fills text_q with one string: escapes, pluses, plain text and some noise
   task automatic build_string();
      int target;
      target = $urandom_range(1, 14);
      text_q.delete();
      while (text_q.size() < target) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               text_q.push_back(CHAR_PERCENT);
               text_q.push_back(pick_digit());
               text_q.push_back(pick_digit());
            end
            4: text_q.push_back(CHAR_PLUS);
            5: text_q.push_back(8'($urandom));
            6: text_q.push_back(CHAR_PERCENT);   // stray escape start
            default: text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
         endcase
      end
      // sometimes chop at the target length, which can cut an escape short
      if ($urandom_range(0, 3) == 0) begin
         while (text_q.size() > target) void'(text_q.pop_back());
      end
   endtask

   task automatic wait_drained();
      @(negedge clock) req_tvalid <= 1'b0;
      while (pending_results != 0) @(posedge clock);
   endtask

   initial begin
      int random_start;
      repeat (12) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: byte extremes, plus, escapes, digit oddities, cut escapes
      send_byte(CHAR_NUL, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(CHAR_PLUS, 1'b0);
      send_byte(CHAR_PERCENT, 1'b0);   // plain escape gives 'A'
      send_byte("4", 1'b0);
      send_byte("1", 1'b0);
      send_byte(CHAR_PERCENT, 1'b0);   // highest digits
      send_byte("F", 1'b0);
      send_byte("9", 1'b0);
      send_byte(CHAR_PERCENT, 1'b0);   // lowercase digit counts as zero
      send_byte("4", 1'b0);
      send_byte("f", 1'b0);
      send_byte(CHAR_PERCENT, 1'b0);   // nul high acts as zero, nul low sets bit 4
      send_byte(CHAR_NUL, 1'b0);
      send_byte(CHAR_NUL, 1'b0);
      send_byte(CHAR_PERCENT, 1'b0);   // percent as a digit, string ends on low digit
      send_byte(CHAR_PERCENT, 1'b0);
      send_byte("Z", 1'b1);
      send_byte(CHAR_PERCENT, 1'b1);   // escape cut at the percent
      send_byte(CHAR_PERCENT, 1'b0);   // escape cut at the high digit
      send_byte("A", 1'b1);
      send_byte(CHAR_PERCENT, 1'b0);   // nul low digit completing at string end
      send_byte("7", 1'b0);
      send_byte(CHAR_NUL, 1'b1);
      send_byte(CHAR_PLUS, 1'b1);

      // hold off until the block has returned everything
      wait_drained();

      // random strings; gap rate changes per string, quiet at the very end
      random_start = items_sent;
      while (items_sent - random_start < RandomItems) begin
         if (items_sent - random_start >= RandomItems - QuietTail) quiet_tail = 1'b1;
         case ($urandom_range(0, 2))
            0: sender_idle_odds = 0;
            1: sender_idle_odds = 3;
            default: sender_idle_odds = 8;
         endcase
         build_string();
         foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
      end

      wait_drained();
      repeat (SettleCycles) @(posedge clock);

      $display("covered %0d requests in %0d strings: %0d escapes decoded, %0d cut short",
               items_sent, strings_seen, escapes_decoded, escapes_dropped);
      $display("random gaps and stalls on both channels, idle-free tail of %0d requests",
               QuietTail);
      if (mismatch_count == 0) begin
         $display("url_percent_decoder test passed");
      end else begin
         $display("url_percent_decoder test failed");
      end
      $finish;
   end

endmodule
